// File: sv/wema_pkg.sv
// wema_pkg: shared widths, register indexes, reset values and control types
// for the warm-up mean and variance estimator
// no dependencies
package wema_pkg;

    // field widths
    localparam int SAMPLE_W  = 32;
    localparam int MEAN_W    = 31;
    localparam int VAR_W     = 64;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int COUNT_W   = 16;
    localparam int MUL_W     = 32;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int DIV_W     = 64;
    localparam int DEN_W     = 16;
    localparam int DIV_CNT_W = 7;

    // stream word widths
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 96;
    localparam int OUT_USER_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WARMUP_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EMA_WEIGHT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTLIER_FACTOR = 2'd2;

    // register reset values
    localparam logic [CFG_W-1:0] WARMUP_COUNT_RST   = 16'd100;
    localparam logic [CFG_W-1:0] EMA_WEIGHT_RST     = 16'd655;
    localparam logic [CFG_W-1:0] OUTLIER_FACTOR_RST = 16'd2560;

    localparam logic [MEAN_W-1:0] MEAN_MAX = {MEAN_W{1'b1}};

    // divider iteration counts: full word, or upper half only
    localparam logic [DIV_CNT_W-1:0] DIV_FULL_ITERS = 7'd64;
    localparam logic [DIV_CNT_W-1:0] DIV_HALF_ITERS = 7'd32;

    // command to the serial divider
    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] iters;
    } div_cmd_t;

endpackage

// File: sv/wema_mul.sv
// wema_mul: shared 32 x 32 unsigned multiplier with a registered product
// depends on wema_pkg
module wema_mul
    import wema_pkg::*;
(
    input  logic              clk,
    input  logic [MUL_W-1:0]  a,
    input  logic [MUL_W-1:0]  b,
    output logic [PROD_W-1:0] p
);

    logic [PROD_W-1:0] p_reg;

    // one product per cycle, ready the cycle after the operands
    always_ff @(posedge clk)
    begin
        p_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign p = p_reg;

endmodule

// File: sv/wema_div.sv
// wema_div: restoring serial divider, 64-bit dividend by 16-bit divisor,
// one quotient bit per cycle; depends on wema_pkg
module wema_div
    import wema_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_cmd_t         cmd,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic [DIV_W-1:0] quotient,
    output logic [DEN_W-1:0] remainder,
    output logic             done
);

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 done_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     den_reg;

    logic [DEN_W:0]   rem_sh;
    logic             fits;
    logic [DEN_W:0]   rem_sub;

    // one restoring step: shift in the next dividend bit, try the subtract
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[DIV_W-1]};
        fits    = rem_sh >= {1'b0, den_reg};
        rem_sub = rem_sh - {1'b0, den_reg};
    end

    // iteration counter and finish flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            cnt_reg  <= cmd.iters;
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                done_reg <= 1'b1;
            end
        end
    end

    // dividend / quotient shift register and partial remainder
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

// File: sv/warmup_ema_mean_variance.sv
// Warm-up mean and variance estimator. Takes one signed Q16.16 sample per input
// word and returns one word with the running mean (unsigned Q15.16), the running variance
// (Q32.32, saturating) and rejected / clamped flags. Negative samples are rejected
// and change nothing; after the first sample, samples above mean times the outlier
// factor are clamped. Below the warm-up count an exact Welford update is used,
// from then on an exponentially weighted one. One word is worked on at a time and
// s_tready is low meanwhile; a finished result waits in the output register so the
// next sample can be taken before it is read. A Welford step runs three passes of
// the serial divider (full word, upper half, full word), each with a start and a
// wait state; the first sample skips the clamp; an exponential step uses the shared
// multiplier; a rejected sample goes straight to the finish state, and a stalled
// output holds the block in the finish state.
// Registers may be written only while the block is idle.
// depends on wema_pkg, wema_mul, wema_div
module warmup_ema_mean_variance
    import wema_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    // sample stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] sample
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [30:0] mean_out, [94:31] variance_out
    output logic [OUT_USER_W-1:0] m_tuser    // [0] rejected, [1] truncated
);

    typedef enum logic [15:0] {
        ST_IDLE = 16'h0001,
        ST_LIM  = 16'h0002,
        ST_DIFF = 16'h0004,
        ST_MSQ  = 16'h0008,
        ST_D2   = 16'h0010,
        ST_V1S  = 16'h0020,
        ST_V1W  = 16'h0040,
        ST_V2S  = 16'h0080,
        ST_V2W  = 16'h0100,
        ST_V3S  = 16'h0200,
        ST_V3W  = 16'h0400,
        ST_E1   = 16'h0800,
        ST_E2   = 16'h1000,
        ST_E3   = 16'h2000,
        ST_E4   = 16'h4000,
        ST_FIN  = 16'h8000
    } wema_state_t;

    wema_state_t state_reg, state_next;

    // configuration and estimator state
    logic [CFG_W-1:0]   warmup_reg, weight_reg, factor_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [MEAN_W-1:0]  mean_reg;
    logic [VAR_W-1:0]   dsum_reg, var_reg;

    // per-word working registers
    logic [MEAN_W-1:0]  x_reg, mag_reg;
    logic               neg_reg, wel_reg, up_reg, rej_reg, trunc_reg;
    logic [COUNT_W-1:0] n_reg;
    logic [VAR_W-1:0]   d2_reg, diff_reg, acc_reg, inc_reg;

    // output register
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_USER_W-1:0] out_user_reg;

    // shared units
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] mul_p;
    div_cmd_t          div_cmd;
    logic [DIV_W-1:0]  div_dividend, div_q;
    logic [DEN_W-1:0]  div_r;
    logic              div_done;

    logic               in_acc, out_free;
    logic [MEAN_W-1:0]  limit_c, mag_c, mean_step_c;
    logic               x_ge_c;
    logic [COUNT_W-1:0] n_c;
    logic [VAR_W:0]     dsum_sum_c;
    logic [VAR_W-1:0]   part_c;

    wema_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    wema_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (div_cmd),
        .dividend  (div_dividend),
        .divisor   (n_reg),
        .quotient  (div_q),
        .remainder (div_r),
        .done      (div_done)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // datapath helpers
    always_comb
    begin
        // clamp limit from mean * factor >> 8, saturated to the mean range
        limit_c = (mul_p[PROD_W-1:39] != '0) ? MEAN_MAX : mul_p[38:8];
        n_c     = (count_reg == '1) ? count_reg : count_reg + 1'b1;
        x_ge_c  = x_reg >= mean_reg;
        mag_c   = x_ge_c ? x_reg - mean_reg : mean_reg - x_reg;
        // exponential mean step: mag * weight >> 16
        mean_step_c = mul_p[46:16];
        dsum_sum_c  = {1'b0, dsum_reg} + {1'b0, inc_reg};
        part_c      = acc_reg + {16'b0, mul_p[PROD_W-1:16]};
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                mul_a = {1'b0, mean_reg};
                mul_b = {16'b0, factor_reg};
            end
            ST_MSQ:
            begin
                mul_a = {1'b0, mag_reg};
                mul_b = {1'b0, mag_reg};
            end
            ST_D2:
            begin
                mul_a = {1'b0, mag_reg};
                mul_b = {16'b0, weight_reg};
            end
            ST_E2:
            begin
                mul_a = diff_reg[63:32];
                mul_b = {16'b0, weight_reg};
            end
            ST_E3:
            begin
                mul_a = diff_reg[31:0];
                mul_b = {16'b0, weight_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divider command select
    always_comb
    begin
        div_cmd.start = 1'b0;
        div_cmd.iters = DIV_FULL_ITERS;
        div_dividend  = d2_reg;
        unique case (state_reg)
            ST_V1S:
            begin
                div_cmd.start = 1'b1;
            end
            ST_V2S:
            begin
                div_cmd.start = 1'b1;
                div_cmd.iters = DIV_HALF_ITERS;
                div_dividend  = {1'b0, mag_reg, 32'b0};
            end
            ST_V3S:
            begin
                div_cmd.start = 1'b1;
                div_dividend  = dsum_reg;
            end
            default:
            begin
                div_cmd.start = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_tdata[SAMPLE_W-1])
                        state_next = ST_FIN;
                    else if (count_reg != '0)
                        state_next = ST_LIM;
                    else
                        state_next = ST_DIFF;
                end
            end
            ST_LIM:  state_next = ST_DIFF;
            ST_DIFF: state_next = ST_MSQ;
            ST_MSQ:  state_next = ST_D2;
            ST_D2:   state_next = wel_reg ? ST_V1S : ST_E1;
            ST_V1S:  state_next = ST_V1W;
            ST_V1W:  state_next = div_done ? ST_V2S : ST_V1W;
            ST_V2S:  state_next = ST_V2W;
            ST_V2W:  state_next = div_done ? ST_V3S : ST_V2W;
            ST_V3S:  state_next = ST_V3W;
            ST_V3W:  state_next = div_done ? ST_FIN : ST_V3W;
            ST_E1:   state_next = ST_E2;
            ST_E2:   state_next = ST_E3;
            ST_E3:   state_next = ST_E4;
            ST_E4:   state_next = ST_FIN;
            ST_FIN:  state_next = out_free ? ST_IDLE : ST_FIN;
            default: state_next = ST_IDLE;
        endcase
    end

    // control, configuration and estimator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            warmup_reg    <= WARMUP_COUNT_RST;
            weight_reg    <= EMA_WEIGHT_RST;
            factor_reg    <= OUTLIER_FACTOR_RST;
            count_reg     <= '0;
            mean_reg      <= '0;
            dsum_reg      <= '0;
            var_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // register writes, unknown indexes ignored
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_WARMUP_COUNT:   warmup_reg <= cfg_data;
                    REG_EMA_WEIGHT:     weight_reg <= cfg_data;
                    REG_OUTLIER_FACTOR: factor_reg <= cfg_data;
                    default:            ;
                endcase
            end

            // welford: saturating deviation sum, mean step, variance
            if (state_reg == ST_V2S)
                dsum_reg <= dsum_sum_c[VAR_W] ? '1 : dsum_sum_c[VAR_W-1:0];
            if (state_reg == ST_V2W && div_done)
                mean_reg <= neg_reg ? mean_reg - div_q[MEAN_W-1:0]
                                    : mean_reg + div_q[MEAN_W-1:0];
            if (state_reg == ST_V3W && div_done)
            begin
                var_reg   <= div_q;
                count_reg <= n_reg;
            end

            // exponential: mean step, then variance step
            if (state_reg == ST_E1)
                mean_reg <= neg_reg ? mean_reg - mean_step_c : mean_reg + mean_step_c;
            if (state_reg == ST_E4)
            begin
                var_reg   <= up_reg ? var_reg + part_c : var_reg - part_c;
                count_reg <= (n_reg < warmup_reg) ? n_reg : warmup_reg;
            end

            // output register
            if (state_reg == ST_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // per-word working registers and output payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            x_reg     <= s_tdata[MEAN_W-1:0];
            rej_reg   <= s_tdata[SAMPLE_W-1];
            trunc_reg <= 1'b0;
        end

        // clamp against mean times outlier factor
        if (state_reg == ST_LIM && x_reg > limit_c)
        begin
            x_reg     <= limit_c;
            trunc_reg <= 1'b1;
        end

        // deviation magnitude and phase choice
        if (state_reg == ST_DIFF)
        begin
            mag_reg <= mag_c;
            neg_reg <= !x_ge_c;
            n_reg   <= n_c;
            wel_reg <= n_c < warmup_reg;
        end

        if (state_reg == ST_D2)
            d2_reg <= mul_p;

        // increment = d2 - ceil(d2 / n)
        if (state_reg == ST_V1W && div_done)
            inc_reg <= d2_reg - div_q - VAR_W'(div_r != '0);

        if (state_reg == ST_E1)
        begin
            up_reg   <= d2_reg >= var_reg;
            diff_reg <= (d2_reg >= var_reg) ? d2_reg - var_reg : var_reg - d2_reg;
        end

        // high half of diff * weight, already scaled by 2^32 / 2^16
        if (state_reg == ST_E3)
            acc_reg <= {mul_p[47:0], 16'b0};

        if (state_reg == ST_FIN && out_free)
        begin
            out_data_reg <= {1'b0, var_reg, mean_reg};
            out_user_reg <= {trunc_reg, rej_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
